[rtl/ibre_pkg.sv]
// Shared constants, action codes and elaboration helpers for the raster engine.
package ibre_pkg;

	// Default geometry
	localparam int ROW_BYTES_DEF  = 90;
	localparam int BANK_BYTES_DEF = 8192;
	localparam int BANKS_DEF      = 4;

	// Field widths
	localparam int ACT_W     = 3;
	localparam int XW        = 10;
	localparam int YW        = 9;
	localparam int BYTE_W    = 8;
	localparam int XB_W      = XW - 3;            // byte column within a row
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 8;

	localparam int Y_MAX  = (1 << YW) - 1;
	localparam int XB_MAX = (1 << XB_W) - 1;

	// Action codes
	localparam logic [ACT_W-1:0] ACT_PLOT  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_READ  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_HSPAN = 3'd2;
	localparam logic [ACT_W-1:0] ACT_VSPAN = 3'd3;
	localparam logic [ACT_W-1:0] ACT_RECT  = 3'd4;

	localparam logic [BYTE_W-1:0] MASK_FULL = 8'hff;

	// Largest k such that depth << k still fits under rmax (0 if none).
	function automatic int red_shift(longint rmax, longint depth);
		int k;
		k = 0;
		for (int i = 0; i < 32; i++) begin
			if ((depth << (i + 1)) <= rmax)
				k = i + 1;
		end
		return k;
	endfunction

endpackage

[rtl/interleaved_bitmap_raster_engine.sv]
// Top level: banked 1-bpp frame store with plot, read, span and rectangle fill.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s       | in  | s_tvalid/s_tready  | s_tuser: action; s_tdata: x_start, y_start,
//          |     |                    |   x_end, y_end, colour
//  m       | out | m_tvalid/m_tready  | m_tdata: pixel_value (read action only)
//
// After reset a clearing pass writes zero to every byte of the store, with
// s_tready low. Per item: an accept step, y/BANKS by reciprocal
// multiplication, the remainder and the row base products, their sum, then
// per row the reduction steps and, per covered byte, a read, then a modify
// and write back. The single RAM port pair is why each byte takes separate
// read and write states. A read result sits in an output register; the engine
// stalls only if a second read finishes while the first result has not been
// transferred.
module interleaved_bitmap_raster_engine #(
	parameter int ROW_BYTES  = ibre_pkg::ROW_BYTES_DEF,
	parameter int BANK_BYTES = ibre_pkg::BANK_BYTES_DEF,
	parameter int BANKS      = ibre_pkg::BANKS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [9:0] x_start, [18:10] y_start, [28:19] x_end, [37:29] y_end, [38] colour
	input  logic [ibre_pkg::S_TDATA_W-1:0]   s_tdata,
	// [2:0] action
	input  logic [ibre_pkg::ACT_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] pixel_value
	output logic [ibre_pkg::M_TDATA_W-1:0]   m_tdata
);

	localparam int XW     = ibre_pkg::XW;
	localparam int YW     = ibre_pkg::YW;
	localparam int XB_W   = ibre_pkg::XB_W;
	localparam int BYTE_W = ibre_pkg::BYTE_W;

	localparam int DEPTH  = BANK_BYTES * BANKS;
	localparam int AW     = $clog2(DEPTH);
	localparam int BW     = (BANKS > 1) ? $clog2(BANKS) : 1;
	// Largest unreduced address: last bank, last row group, last byte column
	localparam int R_MAX  = (BANKS - 1) * BANK_BYTES + (ibre_pkg::Y_MAX / BANKS) * ROW_BYTES
	                      + ibre_pkg::XB_MAX;
	localparam int RW     = $clog2(R_MAX + 1);
	localparam int RED_STEPS = ibre_pkg::red_shift(R_MAX, DEPTH);
	localparam int KW     = (RED_STEPS > 0) ? $clog2(RED_STEPS + 1) : 1;
	localparam int CW     = (RW > AW + 1) ? RW : AW + 1;
	// y/BANKS as (y*RECIP) >> DIV_SH, exact for every 9-bit y and BANKS up to 8
	localparam int DIV_SH = YW + 4;
	localparam int RECIP  = ((1 << DIV_SH) + BANKS - 1) / BANKS;
	localparam int MULW   = YW + DIV_SH + 1;

	localparam logic [RW-1:0]  BB_R     = RW'(BANK_BYTES);
	localparam logic [RW-1:0]  RB_R     = RW'(ROW_BYTES);
	localparam logic [RW-1:0]  WRAP_R   = RW'((BANKS - 1) * BANK_BYTES);
	localparam logic [BW-1:0]  LAST_BANK = BW'(BANKS - 1);
	localparam logic [AW:0]    DEPTH_A  = (AW + 1)'(DEPTH);
	localparam logic [AW-1:0]  LAST_CLR = AW'(DEPTH - 1);
	localparam logic [KW-1:0]  K_INIT   = KW'(RED_STEPS);

	// Sequencer states
	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;
	localparam logic [2:0] ST_RED  = 3'd5;
	localparam logic [2:0] ST_RD   = 3'd6;
	localparam logic [2:0] ST_WR   = 3'd7;

	// Input field split
	logic [ibre_pkg::ACT_W-1:0] in_act;
	logic [XW-1:0]              in_xs, in_xe;
	logic [YW-1:0]              in_ys, in_ye;
	logic                       in_colour;

	assign in_act    = s_tuser;
	assign in_xs     = s_tdata[9:0];
	assign in_ys     = s_tdata[18:10];
	assign in_xe     = s_tdata[28:19];
	assign in_ye     = s_tdata[37:29];
	assign in_colour = s_tdata[38];

	// Control
	logic [2:0]     state_q;
	logic [AW-1:0]  clr_q;
	logic [KW-1:0]  kcnt_q;
	logic           m_tvalid_q;

	// Item payload
	logic [ibre_pkg::ACT_W-1:0] act_q;
	logic [XW-1:0]   xs_q, xe_q;
	logic [YW-1:0]   row_q, ye_q, quo_q;
	logic            colour_q;
	logic [BW-1:0]   bank_q;
	logic [RW-1:0]   prod_bank_q, prod_row_q, r_q, red_q;
	logic [AW-1:0]   addr_q;
	logic [XB_W-1:0] byte_q;
	logic            pixel_q;

	// Accept decode
	logic          skip;
	logic [XW-1:0] xe_eff;
	logic [YW-1:0] ye_eff;

	always_comb begin
		case (in_act)
			ibre_pkg::ACT_PLOT, ibre_pkg::ACT_READ: skip = 1'b0;
			ibre_pkg::ACT_HSPAN: skip = (in_xs > in_xe);
			ibre_pkg::ACT_VSPAN: skip = (in_ys > in_ye);
			ibre_pkg::ACT_RECT:  skip = (in_xs > in_xe) || (in_ys > in_ye);
			default:             skip = 1'b1;
		endcase
	end

	assign xe_eff = (in_act == ibre_pkg::ACT_HSPAN || in_act == ibre_pkg::ACT_RECT)
	                ? in_xe : in_xs;
	assign ye_eff = (in_act == ibre_pkg::ACT_VSPAN || in_act == ibre_pkg::ACT_RECT)
	                ? in_ye : in_ys;

	assign s_tready = (state_q == ST_IDLE);

	// Row split: quotient by reciprocal multiply, remainder picks the bank
	logic [MULW-1:0] recip_prod;
	logic [YW-1:0]   quo_y;
	logic [BW-1:0]   bank_div;

	assign recip_prod = MULW'(row_q * RECIP);
	assign quo_y      = recip_prod[DIV_SH +: YW];
	assign bank_div   = BW'(row_q - YW'(quo_q * BANKS));

	// Shared compare/subtract: modulo-store reduction step
	logic [CW-1:0] cs_a, cs_b, cs_diff;
	logic          cs_ge;

	assign cs_a = CW'(red_q);
	assign cs_b = CW'(DEPTH) << kcnt_q;

	ibre_cmpsub #(.W(CW)) u_cmpsub (
		.a    (cs_a),
		.b    (cs_b),
		.ge   (cs_ge),
		.diff (cs_diff)
	);

	logic [RW-1:0] red_next;
	assign red_next = cs_ge ? RW'(cs_diff) : red_q;

	// Byte masks
	logic [XB_W-1:0]   first_b, last_b;
	logic [BYTE_W-1:0] lmask, rmask, mask_w, rdata, wbyte, ram_wdata;
	logic [AW:0]       addr_inc;
	logic [AW-1:0]     ram_waddr;
	logic              ram_we, out_busy, is_read, res_set;

	assign first_b  = xs_q[XW-1:3];
	assign last_b   = xe_q[XW-1:3];
	assign lmask    = ibre_pkg::MASK_FULL >> xs_q[2:0];
	assign rmask    = ibre_pkg::MASK_FULL << (3'd7 - xe_q[2:0]);
	assign mask_w   = ((byte_q == first_b) ? lmask : ibre_pkg::MASK_FULL)
	                & ((byte_q == last_b) ? rmask : ibre_pkg::MASK_FULL);
	assign wbyte    = colour_q ? (rdata | mask_w) : (rdata & ~mask_w);
	assign addr_inc = {1'b0, addr_q} + (AW + 1)'(1);
	assign out_busy = m_tvalid_q && !m_tready;
	assign is_read  = (act_q == ibre_pkg::ACT_READ);
	// a read result is loaded once the output register is free
	assign res_set  = (state_q == ST_WR) && is_read && !out_busy;

	assign ram_we    = (state_q == ST_CLR) || (state_q == ST_WR && !is_read);
	assign ram_waddr = (state_q == ST_CLR) ? clr_q : addr_q;
	assign ram_wdata = (state_q == ST_CLR) ? '0 : wbyte;

	ibre_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (rdata)
	);

	// Sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			kcnt_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (res_set)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_CLR)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid && !skip)
						state_q <= ST_DIV;
				end
				ST_DIV: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_SUM;
				ST_SUM: begin
					kcnt_q  <= K_INIT;
					state_q <= ST_RED;
				end
				ST_RED: begin
					kcnt_q <= kcnt_q - KW'(1);
					if (kcnt_q == '0)
						state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					if (is_read) begin
						if (!out_busy)
							state_q <= ST_IDLE;
					end else if (byte_q != last_b) begin
						state_q <= ST_RD;
					end else if (row_q != ye_q) begin
						kcnt_q  <= K_INIT;
						state_q <= ST_RED;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					act_q    <= in_act;
					xs_q     <= in_xs;
					xe_q     <= xe_eff;
					ye_q     <= ye_eff;
					row_q    <= in_ys;
					colour_q <= in_colour;
					bank_q   <= '0;
					quo_q    <= '0;
				end
			end
			ST_DIV: begin
				quo_q <= quo_y;
			end
			ST_MUL: begin
				bank_q      <= bank_div;
				prod_bank_q <= RW'(bank_div * BANK_BYTES);
				prod_row_q  <= RW'(quo_q * ROW_BYTES);
			end
			ST_SUM: begin
				r_q    <= prod_bank_q + prod_row_q + RW'(first_b);
				red_q  <= prod_bank_q + prod_row_q + RW'(first_b);
				byte_q <= first_b;
			end
			ST_RED: begin
				red_q <= red_next;
				if (kcnt_q == '0)
					addr_q <= red_next[AW-1:0];
			end
			ST_WR: begin
				if (is_read) begin
					// hold the previous result until it is transferred
					if (!out_busy)
						pixel_q <= |(rdata & mask_w);
				end else if (byte_q != last_b) begin
					byte_q <= byte_q + XB_W'(1);
					addr_q <= (addr_inc == DEPTH_A) ? '0 : addr_inc[AW-1:0];
				end else if (row_q != ye_q) begin
					// next row: step the bank, or wrap to bank 0 of the next row group
					row_q  <= row_q + YW'(1);
					byte_q <= first_b;
					if (bank_q == LAST_BANK) begin
						bank_q <= '0;
						r_q    <= r_q + RB_R - WRAP_R;
						red_q  <= r_q + RB_R - WRAP_R;
					end else begin
						bank_q <= bank_q + BW'(1);
						r_q    <= r_q + BB_R;
						red_q  <= r_q + BB_R;
					end
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = ibre_pkg::M_TDATA_W'(pixel_q);

	// Checks
	a_no_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> !ram_we)
		else $error("store write while accepting an item");

	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_WR && is_read))
		else $error("result raised without a read action");

	a_addr_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (addr_q < DEPTH))
		else $error("byte address beyond the store");

	a_red_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RED) |-> (kcnt_q <= K_INIT))
		else $error("reduction step count out of range");

endmodule

[rtl/ibre_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ibre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[rtl/ibre_cmpsub.sv]
// Shared compare-and-subtract unit used for the store address reduction.
module ibre_cmpsub #(
	parameter int W = 8
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         ge,
	output logic [W-1:0] diff
);

	assign ge   = (a >= b);
	assign diff = a - b;

endmodule
